[design/mbrot_pkg.sv]
// Package for the multibrot escape-time test.
// Word, iteration, power and config types, config indexes and accumulate codes.
// No dependencies.
package mbrot_pkg;

	localparam int WORD_W    = 32;
	localparam int ITER_W    = 10;
	localparam int POW_W     = 4;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [ITER_W-1:0]        iter_t;
	typedef logic [POW_W-1:0]         pow_t;
	typedef logic [CFG_W-1:0]         cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam cfg_idx_t CFG_MAX_ITER = 1'd0;
	localparam cfg_idx_t CFG_POWER    = 1'd1;

	typedef logic [2:0] acc_op_t;

	localparam acc_op_t ACC_NONE    = 3'd0;
	localparam acc_op_t ACC_RE_SET  = 3'd1;
	localparam acc_op_t ACC_RE_SUB  = 3'd2;
	localparam acc_op_t ACC_IM_SET  = 3'd3;
	localparam acc_op_t ACC_IM_ADD  = 3'd4;
	localparam acc_op_t ACC_MAG_SET = 3'd5;
	localparam acc_op_t ACC_MAG_ADD = 3'd6;

endpackage

[design/mandelbrot_escape_test.sv]
// A point that stays bounded runs all N configured updates at clamped power p;
// an escape ends the run early.
// One point per run: the input stalls until the run ends. The single 32x32 multiplier
// issues one product a cycle (4 products per complex multiply, 2 per escape test).
// Reset: asynchronous, active low; iteration limit 20, power 2, no result pending.
// Multibrot escape-time test: one shared multiplier under a small sequencer.
// Uses mbrot_pkg.
module mandelbrot_escape_test #(
	parameter int FRAC_BITS = 28,
	parameter int MAX_POWER = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  mbrot_pkg::cfg_idx_t cfg_index,
	input  mbrot_pkg::cfg_data_t cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  mbrot_pkg::word_t    c_real,
	input  mbrot_pkg::word_t    c_imag,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                in_set
);
	import mbrot_pkg::*;

	localparam int PROD_W = 2 * WORD_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int ESC_SH = 2 * FRAC_BITS + 2;
	localparam bit ESC_ON = (ESC_SH < PROD_W);
	localparam logic [ACC_W-1:0] ESC_LIMIT = ESC_ON ? (ACC_W'(1) << ESC_SH) : '0;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_MWAIT = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_ESC   = 3'd4;
	localparam logic [2:0] ST_EWAIT = 3'd5;
	localparam logic [2:0] ST_ECHK  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [1:0] iss_q;
	iter_t      max_iter_q;
	iter_t      iter_q;
	pow_t       power_q;
	pow_t       cmul_q;
	pow_t       p_eff;
	pow_t       cmul_last;
	logic       res_q;
	logic       out_valid_q;
	logic       in_set_q;

	word_t cr_q, ci_q, zr_q, zi_q, ar_q, ai_q;
	word_t mul_a, mul_b;
	acc_op_t acc_op;
	acc_op_t acc_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  re_q, im_q;
	logic [ACC_W-1:0]         mag_q;

	logic              re_fits, im_fits;
	logic [WORD_W:0]   sum_re, sum_im;
	logic              sum_fits;
	logic              out_free;
	logic              in_xfer;

	always_comb begin
		if (power_q < POW_W'(2))
			p_eff = POW_W'(2);
		else if (int'(power_q) > MAX_POWER)
			p_eff = POW_W'(MAX_POWER);
		else
			p_eff = power_q;
	end
	assign cmul_last = p_eff - POW_W'(1);

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		mul_a  = ar_q;
		mul_b  = zr_q;
		acc_op = ACC_NONE;
		if (state_q == ST_MUL) begin
			case (iss_q)
				2'd0: begin
					mul_a  = ar_q;
					mul_b  = zr_q;
					acc_op = ACC_RE_SET;
				end
				2'd1: begin
					mul_a  = ai_q;
					mul_b  = zi_q;
					acc_op = ACC_RE_SUB;
				end
				2'd2: begin
					mul_a  = ar_q;
					mul_b  = zi_q;
					acc_op = ACC_IM_SET;
				end
				default: begin
					mul_a  = ai_q;
					mul_b  = zr_q;
					acc_op = ACC_IM_ADD;
				end
			endcase
		end else if (state_q == ST_ESC) begin
			if (iss_q == 2'd0) begin
				mul_a  = zr_q;
				mul_b  = zr_q;
				acc_op = ACC_MAG_SET;
			end else begin
				mul_a  = zi_q;
				mul_b  = zi_q;
				acc_op = ACC_MAG_ADD;
			end
		end
	end

	assign prod_sh  = prod_s1 >>> FRAC_BITS;
	assign prod_ext = {prod_sh[PROD_W-1], prod_sh};

	assign re_fits  = (re_q[ACC_W-1:WORD_W-1] == '0) || (re_q[ACC_W-1:WORD_W-1] == '1);
	assign im_fits  = (im_q[ACC_W-1:WORD_W-1] == '0) || (im_q[ACC_W-1:WORD_W-1] == '1);
	assign sum_re   = {re_q[WORD_W-1], re_q[WORD_W-1:0]} + {cr_q[WORD_W-1], cr_q};
	assign sum_im   = {im_q[WORD_W-1], im_q[WORD_W-1:0]} + {ci_q[WORD_W-1], ci_q};
	assign sum_fits = (sum_re[WORD_W] == sum_re[WORD_W-1]) &&
	                  (sum_im[WORD_W] == sum_im[WORD_W-1]);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		case (acc_s1)
			ACC_RE_SET:  re_q  <= prod_ext;
			ACC_RE_SUB:  re_q  <= re_q - prod_ext;
			ACC_IM_SET:  im_q  <= prod_ext;
			ACC_IM_ADD:  im_q  <= im_q + prod_ext;
			ACC_MAG_SET: mag_q <= {1'b0, prod_s1};
			ACC_MAG_ADD: mag_q <= mag_q + {1'b0, prod_s1};
			default: ;
		endcase

		if (in_xfer) begin
			cr_q <= c_real;
			ci_q <= c_imag;
			zr_q <= '0;
			zi_q <= '0;
			ar_q <= '0;
			ai_q <= '0;
		end else if (state_q == ST_FIN && re_fits && im_fits) begin
			if (cmul_q == cmul_last - POW_W'(1)) begin
				zr_q <= sum_re[WORD_W-1:0];
				zi_q <= sum_im[WORD_W-1:0];
			end else begin
				ar_q <= re_q[WORD_W-1:0];
				ai_q <= im_q[WORD_W-1:0];
			end
		end else if (state_q == ST_ECHK) begin
			ar_q <= zr_q;
			ai_q <= zi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			acc_s1      <= ACC_NONE;
			max_iter_q  <= ITER_W'(20);
			power_q     <= POW_W'(2);
			iter_q      <= '0;
			cmul_q      <= '0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			in_set_q    <= 1'b0;
		end else begin
			acc_s1 <= acc_op;

			if (cfg_we) begin
				if (cfg_index == CFG_MAX_ITER)
					max_iter_q <= cfg_data[ITER_W-1:0];
				else if (cfg_index == CFG_POWER)
					power_q <= cfg_data[POW_W-1:0];
			end

			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						iter_q <= '0;
						cmul_q <= '0;
						iss_q  <= '0;
						if (max_iter_q == '0) begin
							res_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					iss_q <= iss_q + 2'd1;
					if (iss_q == 2'd3)
						state_q <= ST_MWAIT;
				end
				ST_MWAIT: state_q <= ST_FIN;
				ST_FIN: begin
					if (!(re_fits && im_fits)) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (cmul_q == cmul_last - POW_W'(1)) begin
						if (!sum_fits) begin
							res_q   <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ESC;
						end
					end else begin
						cmul_q  <= cmul_q + POW_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_ESC: begin
					if (iss_q == 2'd1) begin
						iss_q   <= '0;
						state_q <= ST_EWAIT;
					end else begin
						iss_q <= iss_q + 2'd1;
					end
				end
				ST_EWAIT: state_q <= ST_ECHK;
				ST_ECHK: begin
					cmul_q <= '0;
					if (ESC_ON && (mag_q > ESC_LIMIT)) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (iter_q + ITER_W'(1) == max_iter_q) begin
						res_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						iter_q  <= iter_q + ITER_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						in_set_q <= res_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign in_set    = in_set_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_MUL || state_q == ST_DONE))
		else $error("input transfer did not start a run");

	a_fin_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> ($past(state_q) == ST_MWAIT))
		else $error("product check entered before last product settled");

	a_cmul_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cmul_q < cmul_last))
		else $error("complex multiply count beyond power");

	a_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("finished result not delivered");

endmodule
